// ----- rtl/core/sfcd_pkg.sv -----
`default_nettype none
package sfcd_pkg;

  localparam int PAYLOAD_BYTES = 23;
  localparam int CNT_W         = 5;
  localparam int STORE_W       = 8 * PAYLOAD_BYTES;
  localparam int CHAN_BITS     = 11;
  localparam int IDX_W         = 5;
  localparam int VAL_W         = 12;

  localparam logic [CNT_W-1:0] CNT_FULL      = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_DIGITAL0  = 5'd16;
  localparam logic [IDX_W-1:0] IDX_DIGITAL1  = 5'd17;

  // Bit positions in the flag byte
  localparam int FLAG_BIT_D0   = 0;
  localparam int FLAG_BIT_D1   = 1;
  localparam int FLAG_BIT_LOST = 2;

  localparam logic signed [VAL_W-1:0] CHAN_CENTER = 12'sd1024;
  localparam logic signed [VAL_W-1:0] DIG_HIGH    = 12'sd800;
  localparam logic signed [VAL_W-1:0] DIG_LOW     = -12'sd800;

  localparam logic [7:0] START_BYTE_RST = 8'd15;
  localparam logic [7:0] END_BYTE_RST   = 8'd0;

  // Configuration register indexes
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_END_BYTE   = 1'b1;

  typedef enum logic [1:0] {
    ST_SYNC,
    ST_DATA,
    ST_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear_count;
    logic load_byte;
    logic start_emit;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic start_match;
    logic end_match;
    logic count_full;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/sfcd_ctrl.sv -----
`default_nettype none
module sfcd_ctrl
  import sfcd_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  input  stat_t stat,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic acc;
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r != ST_EMIT);
    acc       = in_tvalid && in_tready;
    unique case (state_r)
      ST_SYNC: begin
        if (acc && stat.start_match) begin
          cmd.clear_count = 1'b1;
          state_nxt       = ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd.load_byte = 1'b1;
          if (stat.count_full) state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (acc) begin
          if (stat.end_match) begin
            cmd.start_emit = 1'b1;
            state_nxt      = ST_EMIT;
          end else begin
            state_nxt = ST_SYNC;
          end
        end
      end
      ST_EMIT: begin
        // advance one result per free output slot
        if (stat.out_free) begin
          cmd.emit_step = 1'b1;
          if (stat.emit_last) state_nxt = ST_SYNC;
        end
      end
      default: state_nxt = ST_SYNC;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/sfcd_dp.sv -----
`default_nettype none
module sfcd_dp
  import sfcd_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire  [7:0]  in_tdata,
  input  wire         cfg_valid,
  input  wire         cfg_index,
  input  wire  [7:0]  cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  wire         out_tready,
  output logic        out_tvalid,
  output logic [23:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic [7:0]         start_byte_r, end_byte_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STORE_W-1:0] store_r, store_nxt;
  logic [7:0]         flags_r;
  logic [IDX_W-1:0]   idx_r;
  logic               out_valid_r;
  logic               status_r, last_r;
  logic [IDX_W-1:0]   oidx_r;
  logic signed [VAL_W-1:0] oval_r, val_nxt;
  logic               lost;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      end_byte_r   <= END_BYTE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte_r <= cfg_data;
        REG_END_BYTE:   end_byte_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lost = flags_r[FLAG_BIT_LOST];

  always_comb begin
    cnt_nxt   = cnt_r;
    store_nxt = store_r;
    if (cmd.clear_count) cnt_nxt = '0;
    else if (cmd.load_byte) cnt_nxt = cnt_r + 1'b1;
    // shift bytes in from the top; byte 0 lands in the low bits
    if (cmd.load_byte) store_nxt = {in_tdata, store_r[STORE_W-1:8]};
    else if (cmd.emit_step) store_nxt = store_r >> CHAN_BITS;
  end

  always_comb begin
    priority if (idx_r == IDX_DIGITAL0) begin
      val_nxt = flags_r[FLAG_BIT_D0] ? DIG_HIGH : DIG_LOW;
    end else if (idx_r == IDX_DIGITAL1) begin
      val_nxt = flags_r[FLAG_BIT_D1] ? DIG_HIGH : DIG_LOW;
    end else begin
      val_nxt = CHAN_CENTER - $signed({1'b0, store_r[CHAN_BITS-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    store_r <= store_nxt;
    if (cmd.start_emit) begin
      flags_r <= store_r[STORE_W-1 -: 8];
      idx_r   <= '0;
    end else if (cmd.emit_step) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.emit_step) begin
      status_r <= lost;
      oidx_r   <= lost ? '0 : idx_r;
      oval_r   <= lost ? '0 : val_nxt;
      last_r   <= lost || (idx_r == IDX_DIGITAL1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.start_match = (in_tdata == start_byte_r);
  assign stat.end_match   = (in_tdata == end_byte_r);
  assign stat.count_full  = (cnt_r == CNT_FULL);
  assign stat.emit_last   = lost || (idx_r == IDX_DIGITAL1);
  assign stat.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, oval_r, oidx_r};
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

// ----- rtl/core/sbus_frame_channel_decoder.sv -----
// SBUS frame decoder.
// Input: in_tvalid/in_tready/in_tdata carries one received byte per item.
// The block hunts for the start byte, collects 23 payload bytes and then
// checks the end byte. A wrong end byte drops the frame with no result.
// Output: out_tvalid/out_tready carries results. A good frame gives 18 items
// (channels 0..15 as 1024 minus the 11-bit raw value, 16 and 17 as +/-800
// from flag bits 0 and 1), out_tlast on the last one. With the frame-lost
// flag set it gives a single item with out_tuser high, index and value zero.
// Configuration: cfg_valid/cfg_index/cfg_data writes start byte (index 0)
// or end byte (index 1); cfg_ready is always high. Write only while idle.
// Throughput: one byte per cycle while hunting and collecting. The emit
// sequencer then shifts the stored frame by 11 bits per result, and
// in_tready stays low while it emits. After the end byte is accepted the
// controller enters its emit state and then loads the first result into
// the output register. A stalled receiver holds the output register and
// the sequencer; in_tready stays low until the last result is loaded.
// Reset: hunting for start byte, registers back to 15 and 0, output empty.
`default_nettype none
module sbus_frame_channel_decoder
  import sfcd_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [4:0] chan_index, [16:5] chan_value, [23:17] zero
  output logic        out_tuser,  // [0] status (frame lost)
  output logic        out_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [7:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // Config writes never stall
  assign cfg_ready = 1'b1;

  sfcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfcd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/core/sfcd_chk.sv -----
`default_nettype none
module sfcd_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire        out_tuser,
  input wire        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 24'd0))
    else $error("frame-lost item malformed");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[4:0] <= 5'd17) && (out_tdata[23:17] == 7'd0))
    else $error("channel index out of range");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tlast == (out_tdata[4:0] == 5'd17)))
    else $error("last marker not on channel 17");

endmodule

bind sbus_frame_channel_decoder sfcd_chk u_sfcd_chk (.*);
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench
  import sfcd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;   // emit sequence is 18 results, leave margin
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 100;  // per random phase, three phases

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_LOST,
    ROW_FLAT
  } row_kind_t;

  // One directed frame: noise bytes, payload fill, flag byte, end byte good or not.
  // ROW_FLAT frames have uniform fill, so every analog channel reads the same.
  typedef struct packed {
    logic [1:0]             noise;
    logic [7:0]             fill;
    logic [7:0]             flags;
    logic                   end_ok;
    logic                   start_inside;
    row_kind_t              kind;
    logic signed [VAL_W-1:0] chan_val;
    logic signed [VAL_W-1:0] d0_val;
    logic signed [VAL_W-1:0] d1_val;
  } frame_row_t;

  typedef struct packed {
    logic             lost;
    logic [IDX_W-1:0] chan;
    logic [VAL_W-1:0] value;
    logic             last;
  } chan_result_t;

  frame_row_t frame_rows [0:6] = '{
    '{2'd0, 8'h00, 8'h00, 1'b1, 1'b0, ROW_FLAT, CHAN_CENTER, DIG_LOW, DIG_LOW},
    '{2'd1, 8'hFF, 8'h03, 1'b1, 1'b0, ROW_FLAT, -12'sd1023, DIG_HIGH, DIG_HIGH},
    '{2'd0, 8'h00, 8'h04, 1'b1, 1'b0, ROW_LOST, '0, '0, '0},
    '{2'd2, 8'hA5, 8'h01, 1'b0, 1'b0, ROW_NONE, '0, '0, '0},
    '{2'd0, 8'h5A, 8'h02, 1'b1, 1'b1, ROW_PREDICT, '0, '0, '0},
    '{2'd0, 8'hFF, 8'hFF, 1'b1, 1'b0, ROW_LOST, '0, '0, '0},
    '{2'd3, 8'hC3, 8'hF8, 1'b1, 1'b0, ROW_PREDICT, '0, '0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_START_BYTE;
  logic [7:0]  cfg_data = '0;

  // Decoder shadow: configuration, parse state and stored payload
  logic [7:0]       start_val = START_BYTE_RST;
  logic [7:0]       end_val = END_BYTE_RST;
  state_t           rx_phase = ST_SYNC;
  logic [CNT_W-1:0] rx_count = '0;
  logic [7:0]       rx_store [PAYLOAD_BYTES];

  chan_result_t channels_due[$];

  int unsigned send_gap_pct = 13;
  int unsigned recv_gap_pct = 88;
  int unsigned frame_bytes_sent = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  sbus_frame_channel_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL sbus_frame_channel_decoder");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic flag_error(input string msg);
    if (error_cnt < 10) begin
      $display("mismatch @%0t: %s", $realtime, msg);
    end
    error_cnt++;
  endtask

  task automatic expect_result(input logic lost, input logic [IDX_W-1:0] chan,
                               input logic [VAL_W-1:0] value, input logic last);
    chan_result_t item;
    item = '{lost, chan, value, last};
    channels_due.push_back(item);
  endtask

  // Advance the shadow parser by one byte; on a good end byte with keep set queue the frame.
  task automatic decode_byte(input logic [7:0] b, input bit keep);
    logic [STORE_W-1:0]   flat;
    logic [CHAN_BITS-1:0] raw;
    logic [7:0]           flags;
    case (rx_phase)
      ST_DATA: begin
        if (rx_count < PAYLOAD_BYTES) rx_store[rx_count] = b;
        rx_count = rx_count + 1'b1;
        if (rx_count >= PAYLOAD_BYTES) rx_phase = ST_END;
      end
      ST_END: begin
        rx_phase = ST_SYNC;
        if (b == end_val && keep) begin
          flags = rx_store[PAYLOAD_BYTES-1];
          if (flags[FLAG_BIT_LOST]) begin
            expect_result(1'b1, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < PAYLOAD_BYTES; i++) flat[i*8 +: 8] = rx_store[i];
            for (int ch = 0; ch < 16; ch++) begin
              raw = flat[ch*CHAN_BITS +: CHAN_BITS];
              expect_result(1'b0, IDX_W'(ch), CHAN_CENTER - VAL_W'(raw), 1'b0);
            end
            expect_result(1'b0, IDX_DIGITAL0, flags[FLAG_BIT_D0] ? DIG_HIGH : DIG_LOW, 1'b0);
            expect_result(1'b0, IDX_DIGITAL1, flags[FLAG_BIT_D1] ? DIG_HIGH : DIG_LOW, 1'b1);
          end
        end
      end
      default: begin
        // hunting for the start byte; an unused phase value behaves the same
        if (b == start_val) begin
          rx_phase = ST_DATA;
          rx_count = '0;
        end else begin
          rx_phase = ST_SYNC;
        end
      end
    endcase
  endtask

  // Offer one byte, with random gaps ahead of it, and hold until it is taken.
  task automatic push_byte(input logic [7:0] b, input bit keep);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (rx_phase != ST_SYNC || b == start_val) frame_bytes_sent++;
    decode_byte(b, keep);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_START_BYTE) start_val = value;
    else end_val = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every queued result, then let the sequencer settle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (channels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random payload; some noise and bad end bytes.
  task automatic send_random_frame();
    logic [7:0] flags;
    int         noise;
    noise = ($urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
    if ($urandom_range(99) < 8) noise = $urandom_range(4, 20);
    repeat (noise) push_byte(8'($urandom), 1'b1);
    push_byte(start_val, 1'b1);
    repeat (PAYLOAD_BYTES - 1) push_byte(8'($urandom), 1'b1);
    flags = 8'($urandom);
    flags[FLAG_BIT_LOST] = ($urandom_range(99) < 20);
    push_byte(flags, 1'b1);
    push_byte(($urandom_range(99) < 85) ? end_val : 8'($urandom), 1'b1);
  endtask

  task automatic random_phase();
    int unsigned target;
    target = frame_bytes_sent + RANDOM_BYTES;
    while (frame_bytes_sent < target) send_random_frame();
  endtask

  always @(posedge clk) begin
    chan_result_t want;
    chan_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[IDX_W-1:0], out_tdata[IDX_W +: VAL_W], out_tlast};
      if (channels_due.size() == 0) begin
        flag_error($sformatf("unexpected item lost=%0b chan=%0d value=%0d last=%0b",
                             got.lost, got.chan, $signed(got.value), got.last));
      end else begin
        want = channels_due.pop_front();
        if (got !== want) begin
          flag_error($sformatf({"expected lost=%0b chan=%0d value=%0d last=%0b, ",
                                "got lost=%0b chan=%0d value=%0d last=%0b"},
                               want.lost, want.chan, $signed(want.value), want.last,
                               got.lost, got.chan, $signed(got.value), got.last));
        end
      end
    end
  end

  initial begin
    logic [7:0] b;
    for (int i = 0; i < PAYLOAD_BYTES; i++) rx_store[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset values of the start and end bytes
    foreach (frame_rows[r]) begin
      repeat (frame_rows[r].noise) push_byte(start_val ^ 8'h80, 1'b1);
      push_byte(start_val, 1'b1);
      for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
        b = (frame_rows[r].start_inside && i == 5) ? start_val : frame_rows[r].fill;
        push_byte(b, frame_rows[r].kind == ROW_PREDICT);
      end
      push_byte(frame_rows[r].flags, frame_rows[r].kind == ROW_PREDICT);
      push_byte(frame_rows[r].end_ok ? end_val : end_val ^ 8'h5A,
                frame_rows[r].kind == ROW_PREDICT);
      case (frame_rows[r].kind)
        ROW_LOST: expect_result(1'b1, '0, '0, 1'b1);
        ROW_FLAT: begin
          for (int ch = 0; ch < 16; ch++) begin
            expect_result(1'b0, IDX_W'(ch), frame_rows[r].chan_val, 1'b0);
          end
          expect_result(1'b0, IDX_DIGITAL0, frame_rows[r].d0_val, 1'b0);
          expect_result(1'b0, IDX_DIGITAL1, frame_rows[r].d1_val, 1'b1);
        end
        default: ;
      endcase
    end
    drain_results();

    // Extremes of both registers, slow receiver then slow sender
    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'hFF);
    random_phase();
    drain_results();

    send_gap_pct = 88;
    recv_gap_pct = 13;
    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_END_BYTE, 8'h00);
    random_phase();
    drain_results();

    // Full rate both sides; open with a long receiver hold to back up the input
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_reg(REG_START_BYTE, 8'($urandom));
    write_reg(REG_END_BYTE, 8'($urandom));
    hold_req = ~hold_req;
    random_phase();
    drain_results();

    if (error_cnt == 0) begin
      $display("PASS sbus_frame_channel_decoder");
    end else begin
      $display("FAIL sbus_frame_channel_decoder");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sfcd_pkg.sv
rtl/core/sfcd_ctrl.sv
rtl/core/sfcd_dp.sv
rtl/core/sbus_frame_channel_decoder.sv
rtl/core/sfcd_chk.sv
sim/testbench.sv
